// File: rtl/fnp_pkg.sv
// film negative pixel effect: shared types and constants
// queue entry layout, config register codes, cast gains and geometry divisors
// no dependencies
package fnp_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PHASE_W   = 12;
  localparam int INDEX_W   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE_MODE = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_index_t;

  localparam logic [CFG_W-1:0]   RESET_WIDTH    = 13'd640;
  localparam logic [CFG_W-1:0]   RESET_HEIGHT   = 13'd480;
  localparam logic [INDEX_W-1:0] HOLE_INDEX_MAX = 8'd255;

  // geometry divisors and truncated 2^16 reciprocals
  localparam logic [7:0]  SPROCKET_DIV   = 8'd12;
  localparam logic [15:0] SPROCKET_RECIP = 16'd5461;
  localparam logic [7:0]  HOLE_DIV       = 8'd25;
  localparam logic [15:0] HOLE_RECIP     = 16'd2621;
  localparam logic [7:0]  BAND_DIV       = 8'd15;
  localparam logic [15:0] BAND_RECIP     = 16'd4369;

  // q16 cast gains
  localparam logic [16:0] FWD_GAIN_R = 17'd75366;
  localparam logic [16:0] FWD_GAIN_G = 17'd68812;
  localparam logic [16:0] FWD_GAIN_B = 17'd55705;
  localparam logic [16:0] REV_GAIN_R = 17'd56987;
  localparam logic [16:0] REV_GAIN_G = 17'd62415;
  localparam logic [16:0] REV_GAIN_B = 17'd77101;
  localparam logic [7:0]  OFFSET_R   = 8'd20;
  localparam logic [7:0]  OFFSET_G   = 8'd10;
  localparam logic [7:0]  OFFSET_B   = 8'd0;

  localparam logic [7:0] BAND_RED   = 8'd220;
  localparam logic [7:0] BAND_GREEN = 8'd150;
  localparam logic [7:0] BAND_BLUE  = 8'd130;
  localparam logic [7:0] HOLE_LEVEL = 8'd240;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0]        red;
    logic [PIX_W-1:0]        green;
    logic [PIX_W-1:0]        blue;
    logic signed [PIX_W-1:0] grain;
    logic                    in_band;
    logic                    hole;
    logic                    frame_end;
    logic                    reverse;
  } fnp_item_t;

endpackage

// File: rtl/fnp_front.sv
// front end: config registers, raster position, sprocket pattern tracking
// classifies each accepted pixel into a queue entry
// depends on fnp_pkg
module fnp_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [fnp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fnp_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [fnp_pkg::PIX_W-1:0]          in_red_in,
  input  logic [fnp_pkg::PIX_W-1:0]          in_green_in,
  input  logic [fnp_pkg::PIX_W-1:0]          in_blue_in,
  input  logic signed [fnp_pkg::PIX_W-1:0]   in_grain_value,
  output fnp_pkg::fnp_item_t                 item
);

  localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int CNT_W  = $clog2(MAX_DIMENSION);
  localparam int SPAN_W = DIM_W + fnp_pkg::INDEX_W;
  localparam int PH_W   = fnp_pkg::PHASE_W;
  localparam int IX_W   = fnp_pkg::INDEX_W;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [fnp_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      return DIM_W'(MAX_DIMENSION);
    end
    return DIM_W'(v);
  endfunction

  // reciprocal multiply, then one correction step
  function automatic logic [DIM_W-1:0] div_const(input logic [DIM_W-1:0] v,
                                                 input logic [7:0] d,
                                                 input logic [15:0] m);
    logic [DIM_W+15:0] prod;
    logic [DIM_W-1:0]  q;
    logic [DIM_W+7:0]  back_mul;
    prod     = (DIM_W+16)'(v) * (DIM_W+16)'(m);
    q        = prod[DIM_W+15:16];
    back_mul = (DIM_W+8)'(q) * (DIM_W+8)'(d);
    if (((DIM_W+8)'(v) - back_mul) >= (DIM_W+8)'(d)) begin
      q = q + DIM_W'(1);
    end
    return q;
  endfunction

  logic             reverse_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] spacing_r;
  logic [DIM_W-1:0] hole_w_r;
  logic [DIM_W-1:0] band_r;
  logic [DIM_W-1:0] wdim;

  assign wdim = eff_dim(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      width_r   <= eff_dim(fnp_pkg::RESET_WIDTH);
      height_r  <= eff_dim(fnp_pkg::RESET_HEIGHT);
      spacing_r <= div_const(eff_dim(fnp_pkg::RESET_WIDTH), fnp_pkg::SPROCKET_DIV,
                             fnp_pkg::SPROCKET_RECIP);
      hole_w_r  <= div_const(eff_dim(fnp_pkg::RESET_WIDTH), fnp_pkg::HOLE_DIV,
                             fnp_pkg::HOLE_RECIP);
      band_r    <= div_const(eff_dim(fnp_pkg::RESET_HEIGHT), fnp_pkg::BAND_DIV,
                             fnp_pkg::BAND_RECIP);
    end else if (cfg_wr_en) begin
      unique case (fnp_pkg::cfg_index_t'(cfg_index))
        fnp_pkg::CFG_REVERSE_MODE: begin
          reverse_r <= cfg_wdata[0];
        end
        fnp_pkg::CFG_IMAGE_WIDTH: begin
          width_r   <= wdim;
          spacing_r <= div_const(wdim, fnp_pkg::SPROCKET_DIV, fnp_pkg::SPROCKET_RECIP);
          hole_w_r  <= div_const(wdim, fnp_pkg::HOLE_DIV, fnp_pkg::HOLE_RECIP);
        end
        fnp_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= wdim;
          band_r   <= div_const(wdim, fnp_pkg::BAND_DIV, fnp_pkg::BAND_RECIP);
        end
        default: begin
        end
      endcase
    end
  end

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [IX_W-1:0]  hidx_r, hidx_nxt;

  logic             wrap_start;
  logic [DIM_W-1:0] x, y, y_tmp, yb, x_inc, y_inc, hr0, hr1;
  logic [PH_W-1:0]  ph0, ph1;
  logic [IX_W-1:0]  idx0;
  logic             roll;
  logic [SPAN_W-1:0] span;
  logic             hole_col, hole_row, in_band;

  always_comb begin
    wrap_start = DIM_W'(col_r) >= width_r;
    x          = wrap_start ? '0 : DIM_W'(col_r);
    y_tmp      = wrap_start ? DIM_W'(row_r) + DIM_W'(1) : DIM_W'(row_r);
    y          = (y_tmp >= height_r) ? '0 : y_tmp;
    yb         = height_r - DIM_W'(1) - y;

    x_inc = x + DIM_W'(1);
    y_inc = y + DIM_W'(1);
    if (x_inc >= width_r) begin
      col_nxt = '0;
      row_nxt = (y_inc >= height_r) ? '0 : CNT_W'(y_inc);
    end else begin
      col_nxt = CNT_W'(x_inc);
      row_nxt = CNT_W'(y);
    end

    // sprocket pattern restarts at each row start
    ph0  = (x == '0) ? PH_W'(spacing_r - (spacing_r >> 2)) : phase_r;
    idx0 = (x == '0) ? '0 : hidx_r;
    roll = (spacing_r != '0) && (32'(ph0) >= 32'(spacing_r));
    ph1  = roll ? '0 : ph0;
    hidx_nxt = (roll && idx0 != fnp_pkg::HOLE_INDEX_MAX) ? idx0 + IX_W'(1) : idx0;
    phase_nxt = ph1 + PH_W'(1);

    span     = SPAN_W'(hidx_nxt) * SPAN_W'(spacing_r);
    hole_col = (spacing_r != '0) && (hidx_nxt != '0) && (span <= SPAN_W'(width_r))
               && (32'(ph1) < 32'(hole_w_r));

    hr0      = band_r >> 2;
    hr1      = hr0 + (band_r >> 1);
    in_band  = (y < band_r) || (yb < band_r);
    hole_row = (y >= hr0 && y < hr1) || (yb >= hr0 && yb < hr1);

    item.red       = in_red_in;
    item.green     = in_green_in;
    item.blue      = in_blue_in;
    item.grain     = in_grain_value;
    item.in_band   = in_band;
    item.hole      = in_band && hole_row && hole_col;
    item.frame_end = (x == width_r - DIM_W'(1)) && (y == height_r - DIM_W'(1));
    item.reverse   = reverse_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      hidx_r  <= '0;
    end else if (in_valid && in_ready) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
    end
  end

endmodule

// File: rtl/fnp_queue.sv
// short queue between the classifying front end and the color back end
// holds fnp_item_t entries, valid/ready on both sides
// depends on fnp_pkg
module fnp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fnp_pkg::fnp_item_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fnp_pkg::fnp_item_t pop_data
);

  localparam int DEPTH = fnp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = fnp_pkg::QUEUE_PTR_W;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fnp_pkg::fnp_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && do_pop && !do_push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count missed a pop");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("queue pointers differ while empty");

endmodule

// File: rtl/fnp_back.sv
// back end: cast, grain, border paint or cast removal, output register
// takes entries from fnp_queue, drives the result channel
// depends on fnp_pkg
module fnp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  output logic                      head_ready,
  input  fnp_pkg::fnp_item_t        head,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [fnp_pkg::PIX_W-1:0] out_red_out,
  output logic [fnp_pkg::PIX_W-1:0] out_green_out,
  output logic [fnp_pkg::PIX_W-1:0] out_blue_out,
  output logic                      out_frame_end
);

  function automatic logic [7:0] sat8(input logic [9:0] v);
    return (v > 10'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] fwd_chan(input logic [7:0] c, input logic [16:0] gain,
                                          input logic [7:0] ofs);
    logic [24:0] prod;
    logic [9:0]  sum;
    prod = 25'(8'd255 - c) * 25'(gain);
    sum  = 10'(prod[24:16]) + 10'(ofs);
    return sat8(sum);
  endfunction

  function automatic logic [7:0] add_grain(input logic [7:0] c,
                                           input logic signed [7:0] g);
    logic signed [9:0] s;
    s = $signed({2'b00, c}) + 10'(g);
    if (s < 10'sd0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic logic [7:0] rev_chan(input logic [7:0] c, input logic [7:0] sub,
                                          input logic [16:0] gain);
    logic [24:0] prod;
    logic [7:0]  diff;
    diff = c - sub;
    prod = 25'(diff) * 25'(gain);
    if (c < sub) begin
      return 8'd0;
    end
    return sat8(10'(prod[24:16]));
  endfunction

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] red_r, green_r, blue_r;
  logic       frame_end_r;
  logic       take;
  logic [7:0] src_r, src_g, src_b;
  logic [7:0] res_r, res_g, res_b;

  assign head_ready = !out_valid_r || out_ready;
  assign take       = head_valid && head_ready;

  always_comb begin
    if (!head.reverse) begin
      res_r = add_grain(fwd_chan(head.red, fnp_pkg::FWD_GAIN_R, fnp_pkg::OFFSET_R), head.grain);
      res_g = add_grain(fwd_chan(head.green, fnp_pkg::FWD_GAIN_G, fnp_pkg::OFFSET_G),
                        head.grain);
      res_b = add_grain(fwd_chan(head.blue, fnp_pkg::FWD_GAIN_B, fnp_pkg::OFFSET_B),
                        head.grain);
      src_r = '0;
      src_g = '0;
      src_b = '0;
      if (head.hole) begin
        res_r = fnp_pkg::HOLE_LEVEL;
        res_g = fnp_pkg::HOLE_LEVEL;
        res_b = fnp_pkg::HOLE_LEVEL;
      end else if (head.in_band) begin
        res_r = fnp_pkg::BAND_RED;
        res_g = fnp_pkg::BAND_GREEN;
        res_b = fnp_pkg::BAND_BLUE;
      end
    end else begin
      // border rows go black first, white after inversion
      src_r = head.in_band ? 8'd0 : head.red;
      src_g = head.in_band ? 8'd0 : head.green;
      src_b = head.in_band ? 8'd0 : head.blue;
      res_r = 8'd255 - rev_chan(src_r, fnp_pkg::OFFSET_R, fnp_pkg::REV_GAIN_R);
      res_g = 8'd255 - rev_chan(src_g, fnp_pkg::OFFSET_G, fnp_pkg::REV_GAIN_G);
      res_b = 8'd255 - rev_chan(src_b, fnp_pkg::OFFSET_B, fnp_pkg::REV_GAIN_B);
    end

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      red_r       <= res_r;
      green_r     <= res_g;
      blue_r      <= res_b;
      frame_end_r <= head.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_frame_end = frame_end_r;

endmodule

// File: rtl/film_negative_pixel_effect.sv
// film negative pixel effect, top level
// front end, two-entry queue and color back end; depends on fnp_pkg,
// fnp_front, fnp_queue, fnp_back
//
// usage:
//   pixels enter on the in_ channel in raster order, one transaction per pixel,
//   and leave on the out_ channel one transaction per pixel, in order
//   cfg_wr_en with cfg_index/cfg_wdata writes reverse mode, width or height;
//   writes take effect on the next pixel and belong between frames or idle time
//   path: an accepted pixel is written into the queue, then into the output register
//   throughput: one pixel per cycle, set by the single-stage front end
//   (position, sprocket pattern, one index-by-spacing multiply) and the
//   single-stage back end (one cast multiply per channel)
//   reset: forward mode, 640 x 480 frame, position and hole pattern at zero;
//   no clearing pass, the block accepts pixels right after reset
//   receiver stall: the output register holds its pixel, the queue absorbs
//   up to two more, then in_ready drops until the receiver takes one
module film_negative_pixel_effect #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [fnp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fnp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fnp_pkg::PIX_W-1:0]        in_red_in,
  input  logic [fnp_pkg::PIX_W-1:0]        in_green_in,
  input  logic [fnp_pkg::PIX_W-1:0]        in_blue_in,
  input  logic signed [fnp_pkg::PIX_W-1:0] in_grain_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fnp_pkg::PIX_W-1:0]        out_red_out,
  output logic [fnp_pkg::PIX_W-1:0]        out_green_out,
  output logic [fnp_pkg::PIX_W-1:0]        out_blue_out,
  output logic                             out_frame_end
);

  fnp_pkg::fnp_item_t front_item;
  fnp_pkg::fnp_item_t head_item;
  logic               head_valid;
  logic               head_ready;

  fnp_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_grain_value (in_grain_value),
    .item           (front_item)
  );

  fnp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_item)
  );

  fnp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_ready    (head_ready),
    .head          (head_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: tb/sv/film_negative_pixel_effect_tb.sv
// testbench for film_negative_pixel_effect: random pixel streams under
// random stalls, checked against an in-bench model of the negative effect
// depends on fnp_pkg and film_negative_pixel_effect
module film_negative_pixel_effect_tb;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int          QUIET_LIMIT = 2000;
  localparam int unsigned FWD_R       = 75366;
  localparam int unsigned FWD_G       = 68812;
  localparam int unsigned FWD_B       = 55705;
  localparam int unsigned REV_R       = 56987;
  localparam int unsigned REV_G       = 62415;
  localparam int unsigned REV_B       = 77101;

  typedef struct packed {
    logic [fnp_pkg::PIX_W-1:0]        red;
    logic [fnp_pkg::PIX_W-1:0]        green;
    logic [fnp_pkg::PIX_W-1:0]        blue;
    logic signed [fnp_pkg::PIX_W-1:0] grain;
  } pixel_in_t;

  typedef struct packed {
    logic [fnp_pkg::PIX_W-1:0] red;
    logic [fnp_pkg::PIX_W-1:0] green;
    logic [fnp_pkg::PIX_W-1:0] blue;
    logic                      frame_end;
  } pixel_out_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  fnp_pkg::cfg_index_t              cfg_index = fnp_pkg::CFG_REVERSE_MODE;
  logic [fnp_pkg::CFG_W-1:0]        cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [fnp_pkg::PIX_W-1:0]        in_red_in = '0;
  logic [fnp_pkg::PIX_W-1:0]        in_green_in = '0;
  logic [fnp_pkg::PIX_W-1:0]        in_blue_in = '0;
  logic signed [fnp_pkg::PIX_W-1:0] in_grain_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [fnp_pkg::PIX_W-1:0]        out_red_out;
  logic [fnp_pkg::PIX_W-1:0]        out_green_out;
  logic [fnp_pkg::PIX_W-1:0]        out_blue_out;
  logic                             out_frame_end;

  // model copy of the registers and the raster position
  logic                      mode_rev;
  logic [fnp_pkg::CFG_W-1:0] width_reg;
  logic [fnp_pkg::CFG_W-1:0] height_reg;
  logic [11:0]               col_pos;
  logic [11:0]               row_pos;
  logic [11:0]               phase_pos;
  logic [7:0]                hole_ctr;

  pixel_in_t  pending_pixels[$];
  pixel_out_t expected_pixels[$];
  int         issued_count = 0;
  int         accepted_count = 0;
  int         results_seen = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  int         send_wait = 0;
  int         send_run = 0;
  bit         send_calm = 1'b0;
  pixel_in_t  next_pix;
  int         hold_left = 0;
  int         recv_run = 0;
  bit         recv_calm = 1'b0;
  pixel_out_t got;
  pixel_out_t want;

  film_negative_pixel_effect dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_grain_value(in_grain_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_end (out_frame_end)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned frame_dim(logic [fnp_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int unsigned clip_hi(int unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic int unsigned add_grain(int unsigned c,
                                            logic signed [fnp_pkg::PIX_W-1:0] g);
    int ci;
    int gi;
    int s;
    ci = c;
    gi = g;
    s = ci + gi;
    if (s < 0) return 0;
    if (s > 255) return 255;
    return s;
  endfunction

  // advances the raster position and returns the processed pixel
  function automatic pixel_out_t process_pixel(pixel_in_t p);
    int unsigned w, h, cx, cy, x, y, yb, band, sp, hw, hr0, hr1, ph, hi;
    int unsigned cr, cg, cb;
    bit          hole_col, hole_row, in_band, hole;
    pixel_out_t  res;
    w = frame_dim(width_reg);
    h = frame_dim(height_reg);
    cx = 32'(col_pos);
    cy = 32'(row_pos);
    ph = 32'(phase_pos);
    hi = 32'(hole_ctr);
    if (cx >= w) begin
      cx = 0;
      cy++;
    end
    if (cy >= h) cy = 0;
    x = cx;
    y = cy;
    yb = h - 1 - y;
    band = h / 15;
    sp = w / 12;
    hw = w / 25;
    hr0 = band / 4;
    hr1 = hr0 + band / 2;
    if (x == 0) begin
      ph = sp - sp / 4;
      hi = 0;
    end
    if (sp > 0 && ph >= sp) begin
      ph = 0;
      if (hi < 255) hi++;
    end
    hole_col = 1'b0;
    if (sp > 0 && hi >= 1) hole_col = ((hi - 1) < w / sp) && (ph < hw);
    in_band = (y < band) || (yb < band);
    hole_row = (y >= hr0 && y < hr1) || (yb >= hr0 && yb < hr1);
    hole = in_band && hole_row && hole_col;

    cr = 32'(p.red);
    cg = 32'(p.green);
    cb = 32'(p.blue);
    if (!mode_rev) begin
      cr = clip_hi((((255 - cr) * FWD_R) >> 16) + 20);
      cg = clip_hi((((255 - cg) * FWD_G) >> 16) + 10);
      cb = clip_hi(((255 - cb) * FWD_B) >> 16);
      cr = add_grain(cr, p.grain);
      cg = add_grain(cg, p.grain);
      cb = add_grain(cb, p.grain);
      if (hole) begin
        cr = 240;
        cg = 240;
        cb = 240;
      end else if (in_band) begin
        cr = 220;
        cg = 150;
        cb = 130;
      end
    end else begin
      if (in_band) begin
        cr = 0;
        cg = 0;
        cb = 0;
      end
      cr = (cr < 20) ? 0 : clip_hi(((cr - 20) * REV_R) >> 16);
      cg = (cg < 10) ? 0 : clip_hi(((cg - 10) * REV_G) >> 16);
      cb = clip_hi((cb * REV_B) >> 16);
      cr = 255 - cr;
      cg = 255 - cg;
      cb = 255 - cb;
    end
    res.red = 8'(cr);
    res.green = 8'(cg);
    res.blue = 8'(cb);
    res.frame_end = (x == w - 1) && (y == h - 1);

    ph = (ph + 1) & 'hFFF;
    cx++;
    if (cx >= w) begin
      cx = 0;
      cy++;
      if (cy >= h) cy = 0;
    end
    col_pos = 12'(cx);
    row_pos = 12'(cy);
    phase_pos = 12'(ph);
    hole_ctr = 8'(hi);
    return res;
  endfunction

  // idle cycles before the next transaction, with stretches of none
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 64);
      calm = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int big_size();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return MAX_DIM;
      2: return 8191;
      default: return $urandom_range(MAX_DIM + 1, 8191);
    endcase
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic add_pixel(int r, int g, int b, int gr);
    pixel_in_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.grain = 8'(gr);
    pending_pixels.push_back(p);
    issued_count++;
  endtask

  task automatic add_random_pixels(int n);
    repeat (n) add_pixel(int'(pick_byte()), int'(pick_byte()), int'(pick_byte()),
                         int'(pick_byte()));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (accepted_count != issued_count || expected_pixels.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(fnp_pkg::cfg_index_t idx, logic [fnp_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      fnp_pkg::CFG_REVERSE_MODE: mode_rev = val[0];
      fnp_pkg::CFG_IMAGE_WIDTH:  width_reg = val;
      fnp_pkg::CFG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(bit rev, int w, int h);
    wait_idle();
    write_reg(fnp_pkg::CFG_REVERSE_MODE, {12'($urandom_range(0, 4095)), rev});
    write_reg(fnp_pkg::CFG_IMAGE_WIDTH, 13'(w));
    write_reg(fnp_pkg::CFG_IMAGE_HEIGHT, 13'(h));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        next_pix = pending_pixels.pop_front();
        in_red_in <= next_pix.red;
        in_green_in <= next_pix.green;
        in_blue_in <= next_pix.blue;
        in_grain_value <= next_pix.grain;
        in_valid <= 1'b1;
        send_wait = draw_wait(send_run, send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_red_out, out_green_out, out_blue_out, out_frame_end};
        results_seen++;
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("pixel %0d: unexpected transaction %0d/%0d/%0d end %0b",
                               results_seen, got.red, got.green, got.blue, got.frame_end));
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want)
            flag_error($sformatf(
              "pixel %0d: expected %0d/%0d/%0d end %0b, got %0d/%0d/%0d end %0b",
              results_seen, want.red, want.green, want.blue, want.frame_end,
              got.red, got.green, got.blue, got.frame_end));
        end
        // long hold-off so the block fills up and stalls its input
        if (results_seen == 40 || $urandom_range(0, 299) == 0)
          hold_left = $urandom_range(80, 200);
        else
          hold_left = draw_wait(recv_run, recv_calm);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready <= (hold_left == 0);
      if (in_valid && in_ready) begin
        expected_pixels.push_back(process_pixel({in_red_in, in_green_in, in_blue_in,
                                                 in_grain_value}));
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("film_negative_pixel_effect_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int w;
    int h;
    int n;
    mode_rev = 1'b0;
    width_reg = fnp_pkg::RESET_WIDTH;
    height_reg = fnp_pkg::RESET_HEIGHT;
    col_pos = '0;
    row_pos = '0;
    phase_pos = '0;
    hole_ctr = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // forward, zero sizes act as a single pixel frame
    configure(1'b0, 0, 0);
    add_pixel(0, 0, 0, 0);
    add_pixel(255, 255, 255, 0);
    add_pixel(0, 0, 0, 127);
    add_pixel(0, 0, 0, -128);
    add_pixel(255, 255, 255, 127);
    add_pixel(255, 255, 255, -128);
    add_pixel(128, 64, 32, -5);
    add_pixel(170, 85, 200, 100);

    // reverse, offsets and clamping
    configure(1'b1, 1, 1);
    add_pixel(0, 0, 0, 0);
    add_pixel(255, 255, 255, -1);
    add_pixel(19, 9, 0, 0);
    add_pixel(20, 10, 1, 0);
    add_pixel(200, 240, 220, 0);
    add_pixel(21, 11, 210, 85);

    // forward, top band row with sprocket holes
    configure(1'b0, 25, 30);
    add_random_pixels(10);

    // one full frame with both bands and holes
    w = $urandom_range(25, 27);
    h = $urandom_range(30, 31);
    configure(1'b0, w, h);
    add_random_pixels(w * h + w);

    while (issued_count < 1000) begin
      case ($urandom_range(0, 3))
        0: begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
          n = w * h * $urandom_range(1, 4);
        end
        1: begin
          w = $urandom_range(12, 24);
          h = $urandom_range(15, 20);
          n = w * $urandom_range(1, h);
        end
        2: begin
          w = big_size();
          h = $urandom_range(0, 1) ? big_size() : int'($urandom_range(1, MAX_DIM));
          n = $urandom_range(10, 60);
        end
        default: begin
          w = $urandom_range(1, 64);
          h = $urandom_range(1, 64);
          n = $urandom_range(1, 100);
        end
      endcase
      configure($urandom_range(0, 2) == 0, w, h);
      add_random_pixels(n);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_pixels.size() == 0)
      $display("film_negative_pixel_effect_tb passed");
    else
      $display("film_negative_pixel_effect_tb failed");
    $finish;
  end

endmodule
